FILE: sv/smx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg: shared types and constants of the softmax vector block
// Beat formats of both channels, the default vector length, and the
// constants of the base-2 exponential approximation.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int SMX_MAX_LEN = 32;

  // Width of the Q0.16 exponential (1.0 needs the seventeenth bit).
  localparam int EXP_W = 17;

  // log2(e) in Q16.
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // 2^(-i/16) in Q16 for i = 0 .. 16.
  localparam logic [16:0] POW2_FRAC [17] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
  } elem_t;

  typedef struct packed {
    logic [15:0] prob;
    logic [5:0]  index;
    logic        final_res;
  } res_t;

endpackage

FILE: sv/smx_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_exp: exp(-d) in Q0.16 for a Q8.8 distance d
// Three-stage pipeline: log2(e) scaling, table interpolation of the
// fractional power of two, and the integer right shift.
// ----------------------------------------------------------------------------
module smx_exp (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] d,
  output logic        e_valid,
  output logic [smx_pkg::EXP_W-1:0] e
);
  import smx_pkg::*;

  logic [32:0] prod;
  logic        v1;
  logic        v2;
  logic [8:0]  k2;
  logic [16:0] th2;
  logic [15:0] dl2;

  logic [16:0] t;
  logic [4:0]  h;
  logic [3:0]  l;
  logic [16:0] tab_diff;
  logic [16:0] m;

  always_comb begin
    t        = prod[32:16];
    h        = {1'b0, t[7:4]};
    l        = t[3:0];
    tab_diff = POW2_FRAC[h] - POW2_FRAC[h + 5'd1];
    m        = th2 - 17'((17'(dl2) + 17'd8) >> 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      e_valid <= 1'b0;
    end else begin
      v1      <= start;
      v2      <= v1;
      e_valid <= v2;
    end
    prod <= 33'(d) * 33'(LOG2E_Q16);
    k2   <= t[16:8];
    th2  <= POW2_FRAC[h];
    dl2  <= 16'(tab_diff[11:0] * l);
    // Beyond sixteen octaves the result underflows to zero.
    if (k2 > 9'd16) begin
      e <= '0;
    end else begin
      e <= m >> k2[4:0];
    end
  end

endmodule

FILE: sv/smx_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_div: restoring divider for (e << 16) / sum
// Produces one quotient bit per cycle; the quotient
// never exceeds 65536 because every exponential is part of the sum.
// ----------------------------------------------------------------------------
module smx_div #(
  parameter int SUM_W = 22
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [smx_pkg::EXP_W-1:0] dividend,
  input  logic [SUM_W-1:0]          divisor,
  output logic                      done,
  output logic [smx_pkg::EXP_W-1:0] q
);
  import smx_pkg::*;

  localparam int REM_W  = SUM_W + 1;
  localparam int STEP_W = $clog2(EXP_W + 1);

  logic [REM_W-1:0]  rem;
  logic [EXP_W-1:0]  dbits;
  logic [STEP_W-1:0] step;
  logic              busy;

  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] reduced;
  logic             fits;

  always_comb begin
    shifted = {rem[SUM_W-1:0], dbits[EXP_W-1]};
    fits    = shifted >= {1'b0, divisor};
    reduced = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // The flag rises together with the last quotient bit.
      done <= busy && !start && (step == STEP_W'(1));
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(EXP_W);
        // The top dividend bits are e >> 1, already below the divisor.
        rem   <= REM_W'(dividend[EXP_W-1:1]);
        dbits <= {dividend[0], {(EXP_W-1){1'b0}}};
        q     <= '0;
      end else if (busy) begin
        rem   <= fits ? reduced : shifted;
        dbits <= dbits << 1;
        q     <= {q[EXP_W-2:0], fits};
        step  <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: sv/softmax_vector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_vector: max-subtracted softmax over a vector of Q8.8 samples
// Loads a vector, then emits one Q0.16 probability per stored element.
// ----------------------------------------------------------------------------
// Elements arrive one beat per cycle on the elem channel while a running
// maximum is kept; at most MAX_LEN are stored and later ones are dropped,
// though a dropped beat that carries last still closes the vector. Once the
// last beat is taken, elem_stall stays high until the final result of the
// vector has been loaded into the output register. The exponential pass
// streams the stored samples through the three-stage exponential pipeline,
// one per cycle. Each probability is then formed by the bit-serial divider,
// which retires one quotient bit per cycle. The elements are handled one
// at a time, each through a memory read, the divider start, the divider
// steps and the output load, which waits while a held result beat is
// stalled. The result beat of the last element carries final_res. A single
// element, or one far above the rest, gives a quotient of 1.0 that is
// reported as 65535.
// ----------------------------------------------------------------------------
module softmax_vector #(
  parameter int MAX_LEN = smx_pkg::SMX_MAX_LEN
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           elem_valid,
  output logic           elem_stall,
  input  smx_pkg::elem_t elem,
  output logic           res_valid,
  input  logic           res_stall,
  output smx_pkg::res_t  res
);
  import smx_pkg::*;

  localparam int AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int SUM_W = $clog2(MAX_LEN) + EXP_W;

  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_EXP     = 3'd1;
  localparam logic [2:0] S_DIV_RD  = 3'd2;
  localparam logic [2:0] S_DIV_GO  = 3'd3;
  localparam logic [2:0] S_DIV_RUN = 3'd4;
  localparam logic [2:0] S_OUT     = 3'd5;

  localparam logic signed [15:0] MAX_RESET = 16'sh8000;

  logic [2:0]              state;
  logic [CNT_W-1:0]        count;
  logic signed [15:0]      running_max;
  logic [SUM_W-1:0]        exp_sum;
  logic [CNT_W-1:0]        rd_cnt;
  logic [CNT_W-1:0]        wr_cnt;
  logic                    rd_v;

  // Sample and exponential stores, one write and one registered read each.
  logic signed [15:0] sample_store [MAX_LEN];
  logic [EXP_W-1:0]   exp_store    [MAX_LEN];
  logic signed [15:0] sample_q;
  logic [EXP_W-1:0]   exp_q;

  logic               elem_take;
  logic               room;
  logic               rd_issue;
  logic [16:0]        dist_wide;
  logic               exp_v;
  logic [EXP_W-1:0]   exp_e;
  logic               div_start;
  logic               div_done;
  logic [EXP_W-1:0]   div_q;
  logic               out_free;
  logic               res_load;
  logic               last_idx;

  always_comb begin
    elem_stall = (state != S_LOAD);
    elem_take  = elem_valid && !elem_stall;
    room       = count < CNT_W'(MAX_LEN);
    rd_issue   = (state == S_EXP) && (rd_cnt < count);
    dist_wide  = {running_max[15], running_max} - {sample_q[15], sample_q};
    div_start  = (state == S_DIV_GO);
    out_free   = !res_valid || !res_stall;
    res_load   = (state == S_OUT) && out_free;
    last_idx   = (rd_cnt == count - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (elem_take && room) begin
      sample_store[count[AW-1:0]] <= elem.value;
    end
    if (rd_issue) begin
      sample_q <= sample_store[rd_cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (exp_v) begin
      exp_store[wr_cnt[AW-1:0]] <= exp_e;
    end
    if (state == S_DIV_RD) begin
      exp_q <= exp_store[rd_cnt[AW-1:0]];
    end
  end

  smx_exp u_exp (
    .clk     (clk),
    .rst     (rst),
    .start   (rd_v),
    .d       (dist_wide[15:0]),
    .e_valid (exp_v),
    .e       (exp_e)
  );

  smx_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (exp_q),
    .divisor  (exp_sum),
    .done     (div_done),
    .q        (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      count       <= '0;
      running_max <= MAX_RESET;
      exp_sum     <= '0;
      rd_cnt      <= '0;
      wr_cnt      <= '0;
      rd_v        <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      rd_v <= rd_issue;
      // A new beat may replace the one that leaves in the same cycle.
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (elem_take) begin
            if (room) begin
              count <= count + CNT_W'(1);
              if (elem.value > running_max) begin
                running_max <= elem.value;
              end
            end
            if (elem.last) begin
              state   <= S_EXP;
              rd_cnt  <= '0;
              wr_cnt  <= '0;
              exp_sum <= '0;
            end
          end
        end
        S_EXP: begin
          if (rd_issue) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end
          if (exp_v) begin
            exp_sum <= exp_sum + SUM_W'(exp_e);
            wr_cnt  <= wr_cnt + CNT_W'(1);
            // All reads are issued by the time the last write returns.
            if (wr_cnt == count - CNT_W'(1)) begin
              state  <= S_DIV_RD;
              rd_cnt <= '0;
            end
          end
        end
        S_DIV_RD: begin
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (res_load) begin
            res.prob      <= div_q[EXP_W-1] ? 16'hFFFF : div_q[15:0];
            res.index     <= 6'(rd_cnt);
            res.final_res <= last_idx;
            if (last_idx) begin
              state       <= S_LOAD;
              count       <= '0;
              running_max <= MAX_RESET;
              exp_sum     <= '0;
            end else begin
              rd_cnt <= rd_cnt + CNT_W'(1);
              state  <= S_DIV_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

FILE: sv/smx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_checker: port-level checks of the softmax vector block
// Watches both channels and is bound to every softmax_vector instance.
// ----------------------------------------------------------------------------
module smx_checker (
  input logic           clk,
  input logic           rst,
  input logic           elem_valid,
  input logic           elem_stall,
  input smx_pkg::elem_t elem,
  input logic           res_valid,
  input logic           res_stall,
  input smx_pkg::res_t  res
);
  import smx_pkg::*;

  // A stalled result beat holds its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result beat changed while stalled");

  // Taking the last element closes the input until the results are out.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    elem_valid && !elem_stall && elem.last |=> elem_stall)
    else $error("input open right after the last element");

  // A new result beat is loaded only while the input is closed.
  a_res_after_load: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(elem_stall))
    else $error("result appeared while loading");

  // A vector of one element has probability one, saturated.
  a_single_sat: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.final_res && (res.index == 6'd0) |-> res.prob == 16'hFFFF)
    else $error("single element not saturated");

endmodule

bind softmax_vector smx_checker u_smx_checker (
  .clk        (clk),
  .rst        (rst),
  .elem_valid (elem_valid),
  .elem_stall (elem_stall),
  .elem       (elem),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .res        (res)
);

FILE: tb/tb_softmax_vector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_softmax_vector: self-checking bench for the softmax vector block
// Sends element vectors with random idle gaps on both channels, predicts
// every probability beat in the bench itself, and compares each result
// beat field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_softmax_vector;

  import smx_pkg::*;

  localparam int VEC_MAX = SMX_MAX_LEN;

  // 2^(-i/16) in Q16, kept here so that the bench does not share the
  // block's own table.
  localparam int unsigned POW2_TBL [17] = '{
    65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
    46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
  };

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  elem_valid = 1'b0;
  logic  elem_stall;
  elem_t elem = '0;
  logic  res_valid;
  logic  res_stall = 1'b0;
  res_t  res;

  softmax_vector i_dut (
    .clk        (clk),
    .rst        (rst),
    .elem_valid (elem_valid),
    .elem_stall (elem_stall),
    .elem       (elem),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Element beats still to be sent, and probability beats still owed.
  elem_t pending_elems[$];
  res_t  expected_probs[$];

  // The bench's own copy of the vector being loaded.
  logic signed [15:0] vec_samples [VEC_MAX];
  logic signed [15:0] vec_max = 16'sh8000;
  int                 vec_len = 0;

  int          errors = 0;
  int          elems_total = 0;
  int          elems_taken = 0;
  int          results_seen = 0;
  bit          elem_sent = 1'b0;
  bit          calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_cnt = 0;

  // One line per mismatch, and a count of them.
  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  // Most gaps are zero or short, a few are long. In a calm stretch there
  // are none at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // exp(-d) for a Q8.8 distance d, as 2^-(d*log2 e) in Q0.16. The integer
  // part of the exponent becomes a right shift; the fraction is found by
  // linear interpolation between sixteenth steps of the table.
  function automatic logic [16:0] exp_neg_q88(input logic [15:0] d);
    longint unsigned t;
    int unsigned     k, f, h, l, diff, m;
    t    = (longint'(d) * 64'd94548) >> 16;
    k    = int'(t >> 8);
    f    = int'(t & 64'd255);
    h    = f >> 4;
    l    = f & 15;
    diff = POW2_TBL[h] - POW2_TBL[h + 1];
    m    = POW2_TBL[h] - ((diff * l + 8) >> 4);
    if (k > 16)
      return 17'd0;
    return 17'(m >> k);
  endfunction

  // Takes one accepted element beat. Elements past the vector capacity are
  // dropped, but a dropped beat with last set still closes the vector and
  // releases a probability beat for every stored element.
  task automatic take_element(input elem_t beat);
    logic [16:0]     exps [VEC_MAX];
    logic [21:0]     exp_total;
    logic [15:0]     delta;
    longint unsigned quot;
    res_t            r;
    if (vec_len < VEC_MAX) begin
      vec_samples[vec_len] = beat.value;
      if (beat.value > vec_max)
        vec_max = beat.value;
      vec_len++;
    end
    if (beat.last) begin
      exp_total = '0;
      for (int i = 0; i < vec_len; i++) begin
        delta     = 16'(vec_max - vec_samples[i]);
        exps[i]   = exp_neg_q88(delta);
        exp_total = exp_total + 22'(exps[i]);
      end
      for (int i = 0; i < vec_len; i++) begin
        quot        = (longint'(exps[i]) << 16) / longint'(exp_total);
        r.prob      = (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
        r.index     = 6'(i);
        r.final_res = (i == vec_len - 1);
        expected_probs.push_back(r);
      end
      vec_max = 16'sh8000;
      vec_len = 0;
    end
  endtask

  function automatic void queue_elem(input int value, input bit last);
    elem_t e;
    e.value = 16'(value);
    e.last  = last;
    pending_elems.push_back(e);
    elems_total++;
  endfunction

  // A vector of random content. The samples sit in a window of random width
  // above a random base, so that narrow windows give many nonzero
  // exponentials and wide ones drive most of them to zero.
  function automatic void queue_random_vector(input int len);
    int unsigned base, spread;
    base = $urandom_range(0, 65535);
    case ($urandom_range(0, 3))
      0:       spread = 15;
      1:       spread = 255;
      2:       spread = 4095;
      default: spread = 65535;
    endcase
    for (int i = 0; i < len; i++)
      queue_elem(int'(base + $urandom_range(0, spread)), i == len - 1);
  endfunction

  // Sender: a new beat is put up at the falling edge once the previous one
  // has been taken, possibly after a random gap. A beat that is waiting
  // keeps its payload until the block accepts it.
  always @(negedge clk) begin
    if (rst) begin
      elem_valid <= 1'b0;
    end else if (!elem_valid || elem_sent) begin
      if (send_gap != 0) begin
        elem_valid <= 1'b0;
        send_gap--;
      end else if (pending_elems.size() != 0) begin
        elem_valid <= 1'b1;
        elem       <= pending_elems.pop_front();
        send_gap   = pick_gap();
      end else begin
        elem_valid <= 1'b0;
      end
    end
    elem_sent = 1'b0;
  end

  // Every element beat the block accepts goes straight into the predictor.
  always @(posedge clk) begin
    if (!rst && elem_valid && !elem_stall) begin
      take_element(elem);
      elem_sent = 1'b1;
      elems_taken++;
    end
  end

  // Receiver: random stalls, overridden by the long hold-off below.
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      res_stall <= 1'b1;
    end else if (recv_gap != 0) begin
      res_stall <= 1'b1;
      recv_gap--;
    end else begin
      res_stall <= 1'b0;
      recv_gap  = pick_gap();
    end
  end

  // Once a few dozen results have come, the receiver holds off for a long
  // stretch while the sender keeps offering beats, so that the block backs
  // up all the way to its input. The same process switches calm stretches
  // with no idling on and off.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt % 256 == 0)
      calm = ($urandom_range(0, 3) == 0);
    if (!rst && !hold_done && results_seen >= 40) begin
      hold_left = 400;
      hold_done = 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
    end
  end

  // Checker: each accepted result beat against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (expected_probs.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat prob=%0d index=%0d final=%0d",
                                  res.prob, res.index, res.final_res));
      end else begin
        want = expected_probs.pop_front();
        if (res.prob !== want.prob)
          report_mismatch($sformatf("prob index %0d: got %0d, want %0d",
                                    want.index, res.prob, want.prob));
        if (res.index !== want.index)
          report_mismatch($sformatf("index: got %0d, want %0d", res.index, want.index));
        if (res.final_res !== want.final_res)
          report_mismatch($sformatf("final_res index %0d: got %0b, want %0b",
                                    want.index, res.final_res, want.final_res));
      end
    end
  end

  initial begin
    int len;
    bit first;

    // Directed vectors. A lone element at either extreme of the range
    // saturates to 65535.
    queue_elem(-32768, 1'b1);
    queue_elem(32767, 1'b1);
    // Largest possible distance: the small element's exponential is zero
    // and the dominant one saturates.
    queue_elem(32767, 1'b0);
    queue_elem(-32768, 1'b1);
    // Equal elements share the probability evenly.
    for (int i = 0; i < 4; i++)
      queue_elem(0, i == 3);
    // Small distances walk through the interpolated table fraction.
    queue_elem(256, 1'b0);
    queue_elem(0, 1'b0);
    queue_elem(-256, 1'b0);
    queue_elem(128, 1'b0);
    queue_elem(16, 1'b0);
    queue_elem(1, 1'b1);
    // Distances around the point where the shift passes sixteen and the
    // exponential drops to zero.
    queue_elem(0, 1'b0);
    queue_elem(-2840, 1'b0);
    queue_elem(-3016, 1'b0);
    queue_elem(-3017, 1'b1);

    // Random vectors, mostly short, some full and some that overflow the
    // store; the first one always overflows and closes on a dropped beat.
    first = 1'b1;
    while (elems_total < 175) begin
      case ($urandom_range(0, 19))
        0, 1:    len = VEC_MAX;
        2:       len = $urandom_range(VEC_MAX + 1, VEC_MAX + 4);
        3, 4, 5: len = $urandom_range(7, 20);
        default: len = $urandom_range(1, 6);
      endcase
      if (first)
        len = VEC_MAX + 2;
      first = 1'b0;
      queue_random_vector(len);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (elems_taken < elems_total)
      @(posedge clk);
    while (expected_probs.size() != 0)
      @(posedge clk);
    // Leave room for any stray beat the block might still put out.
    repeat (200) @(posedge clk);

    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #3ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
